@@ sv/ffca_pkg.sv @@
package ffca_pkg;

    // Tree geometry
    localparam int NUM_BINS   = 1024;
    localparam int LEAF_BITS  = $clog2(NUM_BINS);
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int TREE_DEPTH = 2 << LEAF_BITS;
    localparam int CAP_WIDTH  = 32;

    // Request and result field widths
    localparam int IDX_W     = 10;
    localparam int AMT_W     = 32;
    localparam int BIN_W     = 11;
    localparam int S_TDATA_W = ((IDX_W + AMT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((BIN_W + 7) / 8) * 8;

    // Microcode addressing
    localparam int UPC_BITS = 4;

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [CAP_WIDTH-1:0] cap_t;
    typedef logic [UPC_BITS-1:0]  upc_t;

    // Program steps
    localparam upc_t UPC_CLR   = 4'd0;
    localparam upc_t UPC_IDLE  = 4'd1;
    localparam upc_t UPC_DISP  = 4'd2;
    localparam upc_t UPC_RCHK  = 4'd3;
    localparam upc_t UPC_DESC  = 4'd4;
    localparam upc_t UPC_SUB   = 4'd5;
    localparam upc_t UPC_FIX   = 4'd6;
    localparam upc_t UPC_EMIT  = 4'd7;
    localparam upc_t UPC_LOAD  = 4'd8;
    localparam upc_t UPC_MISS  = 4'd9;

    // Tree memory read address source
    typedef enum logic [2:0] {
        RD_NONE,
        RD_ROOT,
        RD_CHILD,
        RD_DESC,
        RD_SIB
    } rd_sel_t;

    // Tree memory write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_PATH
    } wr_sel_t;

    // Node pointer update
    typedef enum logic [2:0] {
        NODE_HOLD,
        NODE_ROOT,
        NODE_DESC,
        NODE_LEAF,
        NODE_PARENT
    } node_op_t;

    // Path value update
    typedef enum logic [1:0] {
        VAL_HOLD,
        VAL_AMT,
        VAL_SUB,
        VAL_MAX
    } val_op_t;

    // Result register update
    typedef enum logic [1:0] {
        RES_NONE,
        RES_GRANT,
        RES_ACK,
        RES_MISS
    } res_op_t;

    // Jump condition select
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_ACCEPT,
        COND_LOAD,
        COND_MISS,
        COND_DESC_MORE,
        COND_NOT_TOP,
        COND_CLR_LAST,
        COND_OUT_FREE
    } cond_sel_t;

    // Step taken when the condition fails
    typedef enum logic {
        NXT_ADVANCE,
        NXT_HOLD
    } nxt_t;

    typedef struct packed {
        rd_sel_t   rd;
        wr_sel_t   wr;
        node_op_t  node;
        val_op_t   val;
        res_op_t   res;
        cond_sel_t cond;
        nxt_t      on_false;
        upc_t      jump;
        logic      ready;
        logic      emit;
        logic      clr_inc;
    } ctrl_word_t;

    // Status flags sampled by the sequencer
    typedef struct packed {
        logic accept;
        logic is_load;
        logic miss;
        logic desc_more;
        logic not_top;
        logic clr_last;
        logic out_free;
    } cond_t;

    localparam ctrl_word_t CW_NOP = '{
        rd: RD_NONE, wr: WR_NONE, node: NODE_HOLD, val: VAL_HOLD, res: RES_NONE,
        cond: COND_ALWAYS, on_false: NXT_ADVANCE, jump: UPC_IDLE,
        ready: 1'b0, emit: 1'b0, clr_inc: 1'b0
    };

    // Control store
    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t w;
        w = CW_NOP;
        unique case (addr)
            UPC_CLR: begin
                w.wr       = WR_CLEAR;
                w.clr_inc  = 1'b1;
                w.cond     = COND_CLR_LAST;
                w.jump     = UPC_IDLE;
                w.on_false = NXT_HOLD;
            end
            UPC_IDLE: begin
                w.ready    = 1'b1;
                w.cond     = COND_ACCEPT;
                w.jump     = UPC_DISP;
                w.on_false = NXT_HOLD;
            end
            UPC_DISP: begin
                w.node = NODE_ROOT;
                w.rd   = RD_ROOT;
                w.cond = COND_LOAD;
                w.jump = UPC_LOAD;
            end
            UPC_RCHK: begin
                w.rd   = RD_CHILD;
                w.cond = COND_MISS;
                w.jump = UPC_MISS;
            end
            UPC_DESC: begin
                w.node = NODE_DESC;
                w.rd   = RD_DESC;
                w.cond = COND_DESC_MORE;
                w.jump = UPC_DESC;
            end
            UPC_SUB: begin
                w.val  = VAL_SUB;
                w.wr   = WR_PATH;
                w.rd   = RD_SIB;
                w.res  = RES_GRANT;
                w.cond = COND_ALWAYS;
                w.jump = UPC_FIX;
            end
            UPC_FIX: begin
                w.node = NODE_PARENT;
                w.val  = VAL_MAX;
                w.wr   = WR_PATH;
                w.rd   = RD_SIB;
                w.cond = COND_NOT_TOP;
                w.jump = UPC_FIX;
            end
            UPC_EMIT: begin
                w.emit     = 1'b1;
                w.cond     = COND_OUT_FREE;
                w.jump     = UPC_IDLE;
                w.on_false = NXT_HOLD;
            end
            UPC_LOAD: begin
                w.node = NODE_LEAF;
                w.val  = VAL_AMT;
                w.wr   = WR_PATH;
                w.rd   = RD_SIB;
                w.res  = RES_ACK;
                w.cond = COND_ALWAYS;
                w.jump = UPC_FIX;
            end
            UPC_MISS: begin
                w.res  = RES_MISS;
                w.cond = COND_ALWAYS;
                w.jump = UPC_EMIT;
            end
            default: begin
                w.cond = COND_ALWAYS;
                w.jump = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ sv/ffca_ram.sv @@
module ffca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/ffca_sequencer.sv @@
module ffca_sequencer
    import ffca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cond_t      cond_in,
    output ctrl_word_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic hit;

    // Fetch the control word of the current step
    assign ctrl = ucode_rom(upc_reg);

    // Evaluate the selected jump condition
    always_comb begin
        unique case (ctrl.cond)
            COND_ALWAYS:    hit = 1'b1;
            COND_ACCEPT:    hit = cond_in.accept;
            COND_LOAD:      hit = cond_in.is_load;
            COND_MISS:      hit = cond_in.miss;
            COND_DESC_MORE: hit = cond_in.desc_more;
            COND_NOT_TOP:   hit = cond_in.not_top;
            COND_CLR_LAST:  hit = cond_in.clr_last;
            COND_OUT_FREE:  hit = cond_in.out_free;
            default:        hit = 1'b1;
        endcase
    end

    // Jump, hold or advance
    always_comb begin
        if (hit) begin
            upc_next = ctrl.jump;
        end else if (ctrl.on_false == NXT_HOLD) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_CLR;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ sv/first_fit_capacity_allocator_unit.sv @@
// First-fit capacity allocator over a max segment tree of 1024 bins.
//
// Input channel s_*: one request per item. s_tuser is the command (0 = load a
// bin's capacity, 1 = allocate), s_tdata carries bin_index and amount.
// Result channel m_*: one result per request. m_tuser is found, m_tdata is
// the one-based bin number (0 for a load or when no bin fits).
//
// Requests are handled one at a time by a microcoded sequencer that walks a
// tree memory with one read and one write port and registered reads, one tree
// level per cycle.
// From accept to result valid: a load runs a ten-level path fix, a granted
// allocation runs a ten-level descent, a leaf update and a ten-level path
// fix, and a miss goes straight to the result. The sequencer then returns to
// idle before it takes the next request, so requests never overlap.
//
// After reset every bin holds 0: a clearing pass writes all 2048 tree nodes,
// one a cycle, and s_tready stays low until the pass is done.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the sequencer holds on its final step
// until the result register frees up.
module first_fit_capacity_allocator_unit
    import ffca_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // bin_index [9:0], amount [41:10]
    input  logic                 s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // bin_number [10:0]
    output logic                 m_tuser    // found
);

    ctrl_word_t ctrl;
    cond_t      cond;

    logic              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [AMT_W-1:0]  amt_reg;
    node_t             node_reg;
    node_t             node_next;
    cap_t              val_reg;
    cap_t              val_next;
    node_t             clr_reg;
    logic              found_reg;
    logic [BIN_W-1:0]  bin_reg;
    logic              m_tvalid_reg;
    logic              m_found_reg;
    logic [BIN_W-1:0]  m_bin_reg;

    logic              ram_we;
    node_t             ram_waddr;
    cap_t              ram_wdata;
    logic              ram_re;
    node_t             ram_raddr;
    cap_t              ram_rdata;

    logic              accept;
    logic              out_free;
    logic              go_left;

    ffca_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond_in (cond),
        .ctrl    (ctrl)
    );

    ffca_ram #(
        .WIDTH (CAP_WIDTH),
        .DEPTH (TREE_DEPTH)
    ) u_tree (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = ctrl.ready;
    assign accept   = s_tvalid & ctrl.ready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign go_left  = ram_rdata >= amt_reg;

    // Step the node pointer
    always_comb begin
        unique case (ctrl.node)
            NODE_HOLD:   node_next = node_reg;
            NODE_ROOT:   node_next = node_t'(1);
            NODE_DESC:   node_next = {node_reg[NODE_BITS-2:0], ~go_left};
            NODE_LEAF:   node_next = {1'b1, idx_reg};
            NODE_PARENT: node_next = {1'b0, node_reg[NODE_BITS-1:1]};
            default:     node_next = node_reg;
        endcase
    end

    // Update the value carried up the path
    always_comb begin
        unique case (ctrl.val)
            VAL_HOLD: val_next = val_reg;
            VAL_AMT:  val_next = amt_reg;
            VAL_SUB:  val_next = ram_rdata - amt_reg;
            VAL_MAX:  val_next = (val_reg > ram_rdata) ? val_reg : ram_rdata;
            default:  val_next = val_reg;
        endcase
    end

    // Select the tree read address
    always_comb begin
        ram_re    = 1'b1;
        ram_raddr = node_t'(1);
        unique case (ctrl.rd)
            RD_NONE:  ram_re    = 1'b0;
            RD_ROOT:  ram_raddr = node_t'(1);
            RD_CHILD: ram_raddr = {node_reg[NODE_BITS-2:0], 1'b0};
            RD_DESC: begin
                // read the next left child, or the leaf itself at the bottom
                ram_raddr = node_next[LEAF_BITS] ? node_next
                                                 : {node_next[NODE_BITS-2:0], 1'b0};
            end
            RD_SIB:   ram_raddr = node_next ^ node_t'(1);
            default:  ram_re    = 1'b0;
        endcase
    end

    // Select the tree write
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = node_next;
        ram_wdata = val_next;
        unique case (ctrl.wr)
            WR_NONE: ram_we = 1'b0;
            WR_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            WR_PATH: ram_we = 1'b1;
            default: ram_we = 1'b0;
        endcase
    end

    // Flags for the sequencer
    always_comb begin
        cond.accept    = accept;
        cond.is_load   = !cmd_reg;
        cond.miss      = ram_rdata < amt_reg;
        cond.desc_more = !node_next[LEAF_BITS];
        cond.not_top   = node_next != node_t'(1);
        cond.clr_last  = &clr_reg;
        cond.out_free  = out_free;
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_tuser;
            idx_reg <= s_tdata[IDX_W-1:0];
            amt_reg <= s_tdata[IDX_W+AMT_W-1:IDX_W];
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        val_reg  <= val_next;
    end

    // Record the result of the current request
    always_ff @(posedge aclk) begin
        unique case (ctrl.res)
            RES_NONE: begin
            end
            RES_GRANT: begin
                found_reg <= 1'b1;
                bin_reg   <= {1'b0, node_reg[LEAF_BITS-1:0]} + BIN_W'(1);
            end
            RES_ACK: begin
                found_reg <= 1'b1;
                bin_reg   <= '0;
            end
            RES_MISS: begin
                found_reg <= 1'b0;
                bin_reg   <= '0;
            end
            default: begin
            end
        endcase
    end

    // Advance the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (ctrl.clr_inc) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit && out_free) begin
            m_found_reg <= found_reg;
            m_bin_reg   <= bin_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(M_TDATA_W-BIN_W){1'b0}}, m_bin_reg};

endmodule

@@ sv/ffca_checker.sv @@
module ffca_checker
    import ffca_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // No result is shown right after a reset cycle
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A refused request carries no bin number
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[BIN_W-1:0] == '0)
        else $error("bin number on a refused request");

    // Bin numbers stay in range and the pad bits stay zero
    a_bin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[BIN_W-1:0] <= BIN_W'(NUM_BINS))
                     && (m_tdata[M_TDATA_W-1:BIN_W] == '0))
        else $error("bin number out of range");

    // One request at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken back to back");

endmodule

bind first_fit_capacity_allocator_unit ffca_checker u_ffca_checker (.*);

@@ test/first_fit_capacity_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module first_fit_capacity_allocator_unit_tb
    import ffca_pkg::*;
;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_ALLOC = 1'b1
    } cmd_t;

    typedef struct {
        cmd_t              cmd;
        logic [IDX_W-1:0]  bin_index;
        logic [AMT_W-1:0]  amount;
    } request_t;

    typedef struct {
        logic             found;
        logic [BIN_W-1:0] bin_number;
    } grant_t;

    localparam int CALM_FIRST = 700;
    localparam int CALM_LAST  = 1000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // bin_index [9:0], amount [41:10]
    logic                 s_tuser  = 1'b0; // cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // bin_number [10:0]
    logic                 m_tuser;         // found

    request_t pending_requests[$];
    grant_t   expected_grants[$];
    request_t request_on_bus;
    cap_t     cap_tree [1:2*NUM_BINS-1];
    int       accepted_count = 0;
    int       error_count    = 0;

    first_fit_capacity_allocator_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Recompute the maxima from a leaf's parent up to the root
    function automatic void refresh_path(input int leaf);
        int n;
        n = leaf >> 1;
        while (n >= 1) begin
            cap_tree[n] = (cap_tree[2*n] > cap_tree[2*n+1]) ? cap_tree[2*n] : cap_tree[2*n+1];
            n = n >> 1;
        end
    endfunction

    // Apply one accepted request to the tree and queue its grant
    function automatic void first_fit_grant(input request_t req);
        grant_t g;
        int     n;
        g.found      = 1'b1;
        g.bin_number = '0;
        if (req.cmd == CMD_LOAD) begin
            n = NUM_BINS + int'(req.bin_index);
            cap_tree[n] = cap_t'(req.amount);
            refresh_path(n);
        end else if (cap_tree[1] < req.amount) begin
            g.found = 1'b0;
        end else begin
            n = 1;
            while (n < NUM_BINS) begin
                if (cap_tree[2*n] >= req.amount)
                    n = 2 * n;
                else
                    n = 2 * n + 1;
            end
            cap_tree[n] = cap_tree[n] - req.amount;
            refresh_path(n);
            g.bin_number = BIN_W'(n - NUM_BINS + 1);
        end
        expected_grants = {expected_grants, g};
    endfunction

    function automatic bit calm_window();
        return accepted_count >= CALM_FIRST && accepted_count < CALM_LAST;
    endfunction

    function automatic void add_request(input cmd_t cmd, input int unsigned idx,
                                        input logic [AMT_W-1:0] amt);
        request_t r;
        r.cmd       = cmd;
        r.bin_index = IDX_W'(idx);
        r.amount    = amt;
        pending_requests = {pending_requests, r};
    endfunction

    // Drive requests from the pending queue, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                first_fit_grant(request_on_bus);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 &&
                    (calm_window() || $urandom_range(99) >= 32)) begin
                    request_on_bus = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({request_on_bus.amount, request_on_bus.bin_index});
                    s_tuser  <= request_on_bus.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each accepted result against the oldest expected grant
    always @(posedge aclk) begin
        grant_t g;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected result found=%0b bin=%0d",
                             $time, m_tuser, m_tdata[BIN_W-1:0]);
                    error_count++;
                end else begin
                    g = expected_grants.pop_front();
                    if (m_tuser !== g.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, g.found, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[BIN_W-1:0] !== g.bin_number) begin
                        $display("%0t: bin_number mismatch: expected %0d, actual %0d",
                                 $time, g.bin_number, m_tdata[BIN_W-1:0]);
                        error_count++;
                    end
                end
            end
            m_tready <= calm_window() || $urandom_range(99) >= 32;
        end
    end

    // Build the request list, release reset, wait for the drain
    initial begin
        int unsigned      sel;
        logic [AMT_W-1:0] amt;
        int unsigned      idx;

        for (int i = 1; i < 2 * NUM_BINS; i++)
            cap_tree[i] = '0;

        // Zero request and miss on the cleared tree
        add_request(CMD_ALLOC, 0, 32'd0);
        add_request(CMD_ALLOC, 1023, 32'd1);
        // Extreme bins and capacities
        add_request(CMD_LOAD, 0, 32'hFFFF_FFFF);
        add_request(CMD_LOAD, 1023, 32'd100);
        add_request(CMD_ALLOC, 0, 32'hFFFF_FFFF);
        add_request(CMD_ALLOC, 0, 32'hFFFF_FFFF);
        add_request(CMD_ALLOC, 0, 32'd100);
        add_request(CMD_ALLOC, 0, 32'd0);
        // Neighbors across the middle of the tree
        add_request(CMD_LOAD, 511, 32'h7FFF_FFFF);
        add_request(CMD_LOAD, 512, 32'h8000_0000);
        add_request(CMD_ALLOC, 341, 32'h7FFF_FFFF);
        add_request(CMD_ALLOC, 682, 32'h8000_0000);
        add_request(CMD_ALLOC, 0, 32'd1);
        add_request(CMD_ALLOC, 0, 32'h8000_0000);
        // Alternating patterns, then overwrite a bin with zero
        add_request(CMD_LOAD, 341, 32'h5555_5555);
        add_request(CMD_LOAD, 682, 32'hAAAA_AAAA);
        add_request(CMD_ALLOC, 1023, 32'h5555_5556);
        add_request(CMD_ALLOC, 0, 32'h5555_5555);
        add_request(CMD_LOAD, 682, 32'd0);
        add_request(CMD_ALLOC, 0, 32'h0000_0001);
        add_request(CMD_ALLOC, 0, 32'hAAAA_AAAA);

        // Random mix: loads spread over the bins, allocations mostly sized to fit
        for (int i = 0; i < 1650; i++) begin
            idx = ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom_range(1023);
            sel = $urandom_range(99);
            if ($urandom_range(99) < 40) begin
                if (sel < 50)
                    amt = $urandom;
                else if (sel < 75)
                    amt = $urandom_range(1000);
                else
                    amt = $urandom >> $urandom_range(31);
                add_request(CMD_LOAD, idx, amt);
            end else begin
                if (sel < 35)
                    amt = $urandom_range(300);
                else if (sel < 60)
                    amt = $urandom >> $urandom_range(31);
                else if (sel < 75)
                    amt = $urandom;
                else if (sel < 80)
                    amt = '0;
                else
                    amt = $urandom >> $urandom_range(8, 24);
                add_request(CMD_ALLOC, $urandom_range(1023), amt);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_grants.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
